// ===== hdl/ifd_pkg.sv =====
// ifd_pkg: shared constants and types for the imu fall detector
// register indexes, field widths and reset values of the configuration registers
// no dependencies

package ifd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int THR_W     = 16;
  localparam int THR_SQ_W  = 2 * THR_W;
  localparam int ZOFF_W    = 16;
  localparam int TIMEOUT_W = 12;
  localparam int STEP_W    = 8;
  localparam int TICK_W    = 13;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic                    ENABLE_RST    = 1'b0;
  localparam logic [THR_W-1:0]        LOW_THR_RST   = 16'd4096;
  localparam logic [THR_W-1:0]        HIGH_THR_RST  = 16'd24576;
  localparam logic [THR_W-1:0]        ROT_THR_RST   = 16'd45850;
  localparam logic signed [ZOFF_W-1:0] Z_OFFSET_RST = 16'sd3277;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RST   = 12'd1000;
  localparam logic [STEP_W-1:0]       STEP_RST      = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_LOW_THR  = 3'd1,
    CFG_HIGH_THR = 3'd2,
    CFG_ROT_THR  = 3'd3,
    CFG_Z_OFFSET = 3'd4,
    CFG_TIMEOUT  = 3'd5,
    CFG_STEP     = 3'd6
  } cfg_idx_e;

endpackage

// ===== hdl/ifd_if.sv =====
// ifd channel interfaces: sample input, result output and register write
// valid/ready handshake, a transfer happens when both are high at a clock edge
// depends on ifd_pkg

interface ifd_sample_if #(
  parameter int SampleBits = ifd_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] accel_x;
  logic signed [SampleBits-1:0] accel_y;
  logic signed [SampleBits-1:0] accel_z;
  logic signed [SampleBits-1:0] gyro_x;
  logic signed [SampleBits-1:0] gyro_y;
  logic signed [SampleBits-1:0] gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

interface ifd_result_if;
  logic                      valid;
  logic                      ready;
  logic                      fall_event;
  logic                      falling;
  logic                      impact_flag;
  logic                      spin_flag;
  logic [ifd_pkg::TICK_W-1:0] elapsed;

  modport source (output valid, fall_event, falling, impact_flag, spin_flag, elapsed,
                  input ready);
  modport sink (input valid, fall_event, falling, impact_flag, spin_flag, elapsed,
                output ready);
endinterface

interface ifd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ifd_pkg::CFG_IDX_W-1:0]  index;
  logic [ifd_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hdl/imu_fall_detector_unit.sv =====
// imu_fall_detector_unit: threshold fall detection on six-axis imu samples
// three register stages: magnitudes, squares, compare and detector state update
// depends on ifd_pkg and the interfaces in ifd_if.sv
//
//   channel   dir   payload                                          transfer
//   sample_i  in    accel_x/y/z, gyro_x/y/z (SampleBits, signed)     valid & ready
//   result_o  out   fall_event, falling, impact_flag, spin_flag,     valid & ready
//                   elapsed (13 bit)
//   cfg_i     in    index (3 bit), wdata (16 bit)                    valid & ready
//
// one sample per cycle while the result side does not stall; a result is registered through
// the magnitude, square and result stages; the squaring stage has one multiplier per axis,
// SampleBits x SampleBits (AzMagW x AzMagW for z), registered between the magnitude and compare stages
// a stalled result holds the pipeline; ready on the sample side follows the result
// side combinationally through the three stage valid bits
// cfg_i.ready is always high; a register write lands at its transfer edge and the
// squared limits follow in the cycle after
// reset clears the configuration to its defaults, the detector state and all valid bits

module imu_fall_detector_unit
  import ifd_pkg::*;
#(
  parameter int SampleBits = SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifd_sample_if.sink sample_i,
  ifd_result_if.source result_o,
  ifd_cfg_if.sink    cfg_i
);

  localparam int AzMagW = (SampleBits > ZOFF_W) ? SampleBits : ZOFF_W;
  localparam int AzW    = AzMagW + 1;
  localparam int AccW   = 2 * AzMagW + 2;
  localparam int RotW   = 2 * SampleBits + 2;
  localparam int RotCmpW = (RotW > THR_SQ_W) ? RotW : THR_SQ_W;
  localparam int NumAxes = 5;  // accel x, accel y, gyro x, gyro y, gyro z

  // configuration registers
  logic                        enable_q;
  logic [THR_W-1:0]            low_thr_q, high_thr_q, rot_thr_q;
  logic signed [ZOFF_W-1:0]    z_off_q;
  logic [TIMEOUT_W-1:0]        timeout_q;
  logic [STEP_W-1:0]           step_q;
  logic [THR_SQ_W-1:0]         low_sq_q, high_sq_q, rot_sq_q;

  // pipeline
  logic                        s1_valid_q, s2_valid_q, res_valid_q;
  logic                        s1_ready, s2_ready, res_ready;
  logic [SampleBits-1:0]       mag_d   [NumAxes];
  logic [SampleBits-1:0]       s1_mag_q [NumAxes];
  logic [AzMagW-1:0]           s1_az_q;
  logic [2*SampleBits-1:0]     s2_sq_q [NumAxes];
  logic [2*AzMagW-1:0]         s2_azsq_q;

  logic signed [SampleBits-1:0] raw [NumAxes];
  logic signed [AzW-1:0]        az_s;
  logic [AzW-1:0]               az_abs;

  // detector state
  logic              armed_q, impact_q, spin_q;
  logic [TICK_W-1:0] tick_q;
  logic              armed_d, impact_d, spin_d, fall_d;
  logic [TICK_W-1:0] tick_d;
  logic [TICK_W:0]   tick_sum;

  logic [AccW-1:0]    acc2;
  logic [RotCmpW-1:0] rot2;

  // handshake chain
  assign res_ready = !res_valid_q || result_o.ready;
  assign s2_ready  = !s2_valid_q || res_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign sample_i.ready = s1_ready;
  assign cfg_i.ready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= ENABLE_RST;
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      rot_thr_q  <= ROT_THR_RST;
      z_off_q    <= Z_OFFSET_RST;
      timeout_q  <= TIMEOUT_RST;
      step_q     <= STEP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ENABLE:   enable_q   <= cfg_i.wdata[0];
        CFG_LOW_THR:  low_thr_q  <= cfg_i.wdata[THR_W-1:0];
        CFG_HIGH_THR: high_thr_q <= cfg_i.wdata[THR_W-1:0];
        CFG_ROT_THR:  rot_thr_q  <= cfg_i.wdata[THR_W-1:0];
        CFG_Z_OFFSET: z_off_q    <= cfg_i.wdata[ZOFF_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_i.wdata[TIMEOUT_W-1:0];
        CFG_STEP:     step_q     <= cfg_i.wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // squared thresholds, registered from the threshold registers
  always_ff @(posedge clk_i) begin
    low_sq_q  <= low_thr_q * low_thr_q;
    high_sq_q <= high_thr_q * high_thr_q;
    rot_sq_q  <= rot_thr_q * rot_thr_q;
  end

  // stage 1: absolute values, z corrected by the offset
  assign raw[0] = sample_i.accel_x;
  assign raw[1] = sample_i.accel_y;
  assign raw[2] = sample_i.gyro_x;
  assign raw[3] = sample_i.gyro_y;
  assign raw[4] = sample_i.gyro_z;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      mag_d[i] = raw[i][SampleBits-1] ? SampleBits'(-raw[i]) : SampleBits'(raw[i]);
    end
  end

  assign az_s   = AzW'(sample_i.accel_z) - AzW'(z_off_q);
  assign az_abs = az_s[AzW-1] ? AzW'(-az_s) : AzW'(az_s);

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && s1_ready) begin
      s1_mag_q <= mag_d;
      s1_az_q  <= az_abs[AzMagW-1:0];
    end
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      for (int i = 0; i < NumAxes; i++) begin
        s2_sq_q[i] <= s1_mag_q[i] * s1_mag_q[i];
      end
      s2_azsq_q <= s1_az_q * s1_az_q;
    end
  end

  // stage 3: magnitude sums, compares and detector state
  assign acc2 = AccW'(s2_sq_q[0]) + AccW'(s2_sq_q[1]) + AccW'(s2_azsq_q);
  assign rot2 = RotCmpW'(RotW'(s2_sq_q[2]) + RotW'(s2_sq_q[3]) + RotW'(s2_sq_q[4]));

  always_comb begin
    armed_d  = armed_q;
    impact_d = impact_q;
    spin_d   = spin_q;
    fall_d   = 1'b0;
    if (enable_q) begin
      if (acc2 <= AccW'(low_sq_q)) begin
        armed_d = 1'b1;
      end
      if (armed_d) begin
        if (acc2 > AccW'(high_sq_q)) begin
          impact_d = 1'b1;
        end
        if (rot2 > RotCmpW'(rot_sq_q)) begin
          spin_d = 1'b1;
        end
        if (impact_d && spin_d) begin
          fall_d   = 1'b1;
          armed_d  = 1'b0;
          impact_d = 1'b0;
          spin_d   = 1'b0;
        end
      end
    end
    tick_sum = {1'b0, tick_q} + (TICK_W+1)'(step_q);
    tick_d   = tick_q;
    if (armed_d) begin
      tick_d = (tick_sum > (TICK_W+1)'(TICK_MAX)) ? TICK_MAX : tick_sum[TICK_W-1:0];
    end
    // timeout abandons the armed state unless this sample completed a fall
    if (!fall_d && (tick_d > TICK_W'(timeout_q))) begin
      tick_d   = '0;
      armed_d  = 1'b0;
      impact_d = 1'b0;
      spin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      impact_q <= 1'b0;
      spin_q   <= 1'b0;
      tick_q   <= '0;
    end else if (s2_valid_q && res_ready) begin
      armed_q  <= armed_d;
      impact_q <= impact_d;
      spin_q   <= spin_d;
      tick_q   <= tick_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && res_ready) begin
      result_o.fall_event  <= fall_d;
      result_o.falling     <= armed_d;
      result_o.impact_flag <= impact_d;
      result_o.spin_flag   <= spin_d;
      result_o.elapsed     <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (res_ready) begin
        res_valid_q <= s2_valid_q;
      end
    end
  end

  assign result_o.valid = res_valid_q;

  // flags only live while armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (impact_q || spin_q) |-> armed_q)
    else $error("impact or spin flag set while not armed");

  // an empty result register never blocks the sample side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> sample_i.ready)
    else $error("sample side stalled with empty result stage");

  // a reported fall leaves the detector disarmed with clear flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.fall_event) |->
      (!result_o.falling && !result_o.impact_flag && !result_o.spin_flag))
    else $error("fall reported without clearing the detector");

  // a state update without a fall never leaves the counter past the timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && res_ready && !fall_d) |=> (tick_q <= TICK_W'(timeout_q)))
    else $error("tick counter beyond timeout after update");

endmodule

// ===== sim/imu_fall_detector_unit_test.sv =====
// imu_fall_detector_unit_test: self-checking bench for the imu fall detector unit
// drives samples and register writes, predicts each result and checks it field by field
// depends on ifd_pkg, the channel interfaces and imu_fall_detector_unit
`timescale 1ns / 100ps

module imu_fall_detector_unit_test;
  import ifd_pkg::*;

  localparam int DrainLimit = 20000;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
  } sample_t;

  typedef struct packed {
    logic              fall_event;
    logic              falling;
    logic              impact_flag;
    logic              spin_flag;
    logic [TICK_W-1:0] elapsed;
  } status_t;

  typedef enum {
    KIND_FREEFALL, KIND_QUIET, KIND_IMPACT, KIND_SPIN, KIND_IMPACT_SPIN, KIND_NOISE
  } motion_e;

  logic clk;
  logic rst_n;

  ifd_sample_if sample_ch ();
  ifd_result_if result_ch ();
  ifd_cfg_if    cfg_ch ();

  imu_fall_detector_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_ch.sink),
    .result_o(result_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  // shadow of the configuration registers
  logic                 enable_r;
  logic [THR_W-1:0]     low_thr_r;
  logic [THR_W-1:0]     high_thr_r;
  logic [THR_W-1:0]     rot_thr_r;
  logic [ZOFF_W-1:0]    z_offset_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [STEP_W-1:0]    step_r;

  // shadow of the detector state
  logic              armed_r;
  logic              impact_r;
  logic              spin_r;
  logic [TICK_W-1:0] ticks_r;

  status_t predicted_status[$];

  int error_count;
  int samples_sent;
  int results_checked;
  int falls_predicted;
  int timeouts_predicted;
  int reg_writes;
  bit sender_gaps_on;
  bit receiver_stalls_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #3_000_000;
    $display("imu_fall_detector_unit_test failed");
    $finish;
  end

  function automatic status_t predict_fall_status(sample_t s);
    longint            ax, ay, az, gx, gy, gz;
    longint unsigned   acc_sq, rot_sq, low_sq, high_sq, rot_lim_sq, lim;
    int unsigned       next_ticks;
    logic              fall;
    status_t           r;
    ax = longint'($signed(s.ax));
    ay = longint'($signed(s.ay));
    az = longint'($signed(s.az)) - longint'($signed(z_offset_r));
    gx = longint'($signed(s.gx));
    gy = longint'($signed(s.gy));
    gz = longint'($signed(s.gz));
    acc_sq = ax * ax + ay * ay + az * az;
    rot_sq = gx * gx + gy * gy + gz * gz;
    lim = low_thr_r;
    low_sq = lim * lim;
    lim = high_thr_r;
    high_sq = lim * lim;
    lim = rot_thr_r;
    rot_lim_sq = lim * lim;
    fall = 1'b0;
    if (enable_r) begin
      if (acc_sq <= low_sq) armed_r = 1'b1;
      if (armed_r) begin
        if (acc_sq > high_sq) impact_r = 1'b1;
        if (rot_sq > rot_lim_sq) spin_r = 1'b1;
        if (impact_r && spin_r) begin
          fall = 1'b1;
          armed_r = 1'b0;
          impact_r = 1'b0;
          spin_r = 1'b0;
        end
      end
    end
    if (armed_r) begin
      next_ticks = ticks_r + step_r;
      ticks_r = (next_ticks > TICK_MAX) ? TICK_MAX : next_ticks[TICK_W-1:0];
    end
    // timeout runs whether or not the detector is enabled
    if (!fall && ticks_r > timeout_r) begin
      ticks_r = '0;
      armed_r = 1'b0;
      impact_r = 1'b0;
      spin_r = 1'b0;
      timeouts_predicted++;
    end
    if (fall) falls_predicted++;
    r.fall_event = fall;
    r.falling = armed_r;
    r.impact_flag = impact_r;
    r.spin_flag = spin_r;
    r.elapsed = ticks_r;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int spread(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int big_value(int lo);
    int v;
    v = int'($urandom_range(lo, 32767));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz);
    sample_t s;
    s.ax = clamp16(ax);
    s.ay = clamp16(ay);
    s.az = clamp16(az);
    s.gx = clamp16(gx);
    s.gy = clamp16(gy);
    s.gz = clamp16(gz);
    return s;
  endfunction

  function automatic sample_t make_sample(motion_e kind);
    int zoff;
    int lim;
    zoff = $signed(z_offset_r);
    lim = low_thr_r / 2;
    case (kind)
      KIND_FREEFALL: begin
        return mk(spread(lim), spread(lim), zoff + spread(lim),
                  spread(3000), spread(3000), spread(3000));
      end
      KIND_QUIET: begin
        return mk(spread(2000), spread(2000), zoff + 16384 + spread(2000),
                  spread(2000), spread(2000), spread(2000));
      end
      KIND_IMPACT: begin
        return mk(big_value(16384), big_value(8000), zoff + big_value(8000),
                  spread(2000), spread(2000), spread(2000));
      end
      KIND_SPIN: begin
        return mk(spread(2000), spread(2000), zoff + spread(2000),
                  big_value(20000), big_value(20000), big_value(20000));
      end
      KIND_IMPACT_SPIN: begin
        return mk(big_value(16384), big_value(8000), zoff + big_value(8000),
                  big_value(20000), big_value(20000), big_value(20000));
      end
      default: begin
        return mk($signed(16'($urandom())), $signed(16'($urandom())),
                  $signed(16'($urandom())), $signed(16'($urandom())),
                  $signed(16'($urandom())), $signed(16'($urandom())));
      end
    endcase
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= s.ax;
    sample_ch.accel_y <= s.ay;
    sample_ch.accel_z <= s.az;
    sample_ch.gyro_x  <= s.gx;
    sample_ch.gyro_y  <= s.gy;
    sample_ch.gyro_z  <= s.gz;
    do @(posedge clk); while (!sample_ch.ready);
    predicted_status.push_back(predict_fall_status(s));
    samples_sent++;
  endtask

  // waits until every predicted result has been checked and the pipeline is empty
  task automatic wait_drained();
    int waited;
    sample_ch.valid <= 1'b0;
    waited = 0;
    while (predicted_status.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_status.size() != 0) begin
      $error("results missing: %0d still expected", predicted_status.size());
      error_count++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ENABLE:   enable_r = value[0];
      CFG_LOW_THR:  low_thr_r = value;
      CFG_HIGH_THR: high_thr_r = value;
      CFG_ROT_THR:  rot_thr_r = value;
      CFG_Z_OFFSET: z_offset_r = value;
      CFG_TIMEOUT:  timeout_r = value[TIMEOUT_W-1:0];
      CFG_STEP:     step_r = value[STEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(logic en, logic [15:0] low, logic [15:0] high,
                                logic [15:0] rot, logic [15:0] zoff,
                                logic [15:0] tmo, logic [15:0] stp);
    write_reg(CFG_ENABLE, {15'd0, en});
    write_reg(CFG_LOW_THR, low);
    write_reg(CFG_HIGH_THR, high);
    write_reg(CFG_ROT_THR, rot);
    write_reg(CFG_Z_OFFSET, zoff);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_STEP, stp);
  endtask

  // result side: draws a stall before each transfer
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_stalls_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (predicted_status.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        want = predicted_status.pop_front();
        results_checked++;
        if (result_ch.fall_event !== want.fall_event) begin
          $error("fall_event: expected %0d, actual %0d", want.fall_event,
                 result_ch.fall_event);
          error_count++;
        end
        if (result_ch.falling !== want.falling) begin
          $error("falling: expected %0d, actual %0d", want.falling, result_ch.falling);
          error_count++;
        end
        if (result_ch.impact_flag !== want.impact_flag) begin
          $error("impact_flag: expected %0d, actual %0d", want.impact_flag,
                 result_ch.impact_flag);
          error_count++;
        end
        if (result_ch.spin_flag !== want.spin_flag) begin
          $error("spin_flag: expected %0d, actual %0d", want.spin_flag,
                 result_ch.spin_flag);
          error_count++;
        end
        if (result_ch.elapsed !== want.elapsed) begin
          $error("elapsed: expected %0d, actual %0d", want.elapsed, result_ch.elapsed);
          error_count++;
        end
      end
    end
  end

  // detector is off out of reset, so even a free-fall sample must not arm it
  task automatic test_disabled_after_reset();
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    wait_drained();
  endtask

  task automatic test_fall_sequence();
    write_reg(CFG_ENABLE, 16'd1);
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(0, 0, 3277 + 16384, 0, 0, 0));
    send_sample(mk(32767, 0, 0, 0, 0, 0));
    send_sample(mk(0, 0, 3277, 32767, -32768, 0));
    // impact and spin in the same sample
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    wait_drained();
  endtask

  // low limit zero arms only on exact zero, high and rotation limits trip on any nonzero magnitude
  task automatic test_zero_thresholds();
    write_reg(CFG_LOW_THR, 16'd0);
    write_reg(CFG_HIGH_THR, 16'd0);
    write_reg(CFG_ROT_THR, 16'd0);
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(1, 0, 3277, 0, 0, 0));
    send_sample(mk(0, 0, 3277, 0, 0, 1));
    send_sample(mk(0, 1, 3277, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_timeout_and_counter();
    write_reg(CFG_LOW_THR, LOW_THR_RST);
    write_reg(CFG_HIGH_THR, HIGH_THR_RST);
    write_reg(CFG_ROT_THR, ROT_THR_RST);
    write_reg(CFG_TIMEOUT, 16'd600);
    write_reg(CFG_STEP, 16'd255);
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    repeat (3) send_sample(mk(100, -100, 3277 + 16384, 0, 0, 0));
    // counter survives a fall and is cleared by a later timeout
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(32767, 0, 3277, 32767, 32767, 0));
    send_sample(mk(0, 0, 3277 + 16384, 0, 0, 0));
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    wait_drained();
    // disabled while armed: ticks keep running until the timeout
    write_reg(CFG_ENABLE, 16'd0);
    repeat (3) send_sample(mk(0, 0, 3277, 32767, 32767, 32767));
    wait_drained();
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_STEP, 16'd0);
    send_sample(mk(0, 0, 3277, 0, 0, 0));
    send_sample(mk(0, 0, 3277 + 16384, 0, 0, 0));
    wait_drained();
  endtask

  task automatic run_motion_traffic(int count);
    int      n;
    int      len;
    motion_e kind;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_sample(make_sample(KIND_FREEFALL));
        n++;
        len = $urandom_range(0, 6);
        repeat (len) begin
          kind = motion_e'($urandom_range(0, 5));
          send_sample(make_sample(kind));
          n++;
        end
      end else begin
        send_sample(make_sample(KIND_NOISE));
        n++;
      end
    end
  endtask

  task automatic test_random_motion();
    for (int phase = 0; phase < 8; phase++) begin
      sender_gaps_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      receiver_stalls_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      case (phase)
        0: write_all_regs(1'b1, LOW_THR_RST, HIGH_THR_RST, ROT_THR_RST, Z_OFFSET_RST,
                          16'(TIMEOUT_RST), 16'(STEP_RST));
        1: write_all_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'd4095, 16'd255);
        2: write_all_regs(1'b1, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0);
        7: write_all_regs(1'b0, 16'($urandom_range(0, 12000)), 16'($urandom()),
                          16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 4095)),
                          16'($urandom_range(0, 255)));
        default: write_all_regs(1'b1, 16'($urandom_range(0, 12000)),
                                16'($urandom_range(8000, 40000)),
                                16'($urandom_range(20000, 60000)),
                                16'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 8000)),
                                16'($urandom_range(0, 4095)), 16'($urandom_range(0, 255)));
      endcase
      run_motion_traffic(192);
      wait_drained();
    end
  endtask

  initial begin
    error_count = 0;
    samples_sent = 0;
    results_checked = 0;
    falls_predicted = 0;
    timeouts_predicted = 0;
    reg_writes = 0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    enable_r = ENABLE_RST;
    low_thr_r = LOW_THR_RST;
    high_thr_r = HIGH_THR_RST;
    rot_thr_r = ROT_THR_RST;
    z_offset_r = Z_OFFSET_RST;
    timeout_r = TIMEOUT_RST;
    step_r = STEP_RST;
    armed_r = 1'b0;
    impact_r = 1'b0;
    spin_r = 1'b0;
    ticks_r = '0;
    rst_n <= 1'b0;
    sample_ch.valid <= 1'b0;
    sample_ch.accel_x <= '0;
    sample_ch.accel_y <= '0;
    sample_ch.accel_z <= '0;
    sample_ch.gyro_x <= '0;
    sample_ch.gyro_y <= '0;
    sample_ch.gyro_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ENABLE;
    cfg_ch.wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_after_reset();
    test_fall_sequence();
    test_zero_thresholds();
    test_timeout_and_counter();
    test_random_motion();
    wait_drained();

    $display("checked %0d results for %0d samples over %0d register writes",
             results_checked, samples_sent, reg_writes);
    $display("falls predicted: %0d, timeouts predicted: %0d, mismatches: %0d",
             falls_predicted, timeouts_predicted, error_count);
    if (error_count == 0) begin
      $display("imu_fall_detector_unit_test passed");
    end else begin
      $display("imu_fall_detector_unit_test failed");
    end
    $finish;
  end

endmodule
